// ===== rtl/core/atcf_pkg.sv =====
// shared types, constants and helper functions for the terminal command formatter
`timescale 1ns / 1ps
`default_nettype none

package atcf_pkg;

    localparam int SCREEN_ROWS   = 24;
    localparam int SCREEN_COLS   = 80;
    localparam int QUEUE_DEPTH   = 2;
    localparam int NSEG          = 4;

    localparam logic [4:0] ROW_MAX       = 5'(SCREEN_ROWS - 1);
    localparam logic [6:0] COL_MAX       = 7'(SCREEN_COLS - 1);
    localparam logic [6:0] PUT_COL_LIMIT = 7'd79;

    // command codes
    localparam logic [3:0] CMD_PUT     = 4'd0;
    localparam logic [3:0] CMD_SETCUR  = 4'd1;
    localparam logic [3:0] CMD_WINDOW  = 4'd2;
    localparam logic [3:0] CMD_DELROWS = 4'd3;
    localparam logic [3:0] CMD_INSROWS = 4'd4;
    localparam logic [3:0] CMD_CLEAR   = 4'd5;
    localparam logic [3:0] CMD_EOL     = 4'd6;
    localparam logic [3:0] CMD_ATTR    = 4'd7;
    localparam logic [3:0] CMD_INIT    = 4'd8;
    localparam logic [3:0] CMD_RESTORE = 4'd9;

    // segment kinds
    localparam logic [1:0] SEG_STR  = 2'd0;
    localparam logic [1:0] SEG_CHR  = 2'd1;
    localparam logic [1:0] SEG_CSI1 = 2'd2;
    localparam logic [1:0] SEG_CSI2 = 2'd3;

    // fixed escape strings
    localparam logic [7:0] STR_INV      = 8'd0;
    localparam logic [7:0] STR_NORM     = 8'd1;
    localparam logic [7:0] STR_WRAP_OFF = 8'd2;
    localparam logic [7:0] STR_WRAP_ON  = 8'd3;
    localparam logic [7:0] STR_CLEAR    = 8'd4;
    localparam logic [7:0] STR_EOL      = 8'd5;

    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_LB   = 8'h5b;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_M    = 8'h4d;
    localparam logic [7:0] CH_L    = 8'h4c;

    typedef struct packed {
        logic [1:0] ndig;
        logic [1:0] hun;
        logic [3:0] ten;
        logic [3:0] one;
    } dec_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
        dec_t       num1;
        dec_t       num2;
    } seg_t;

    typedef struct packed {
        seg_t [NSEG-1:0] seg;
        logic [1:0]      last_seg;
        logic [4:0]      cursor_row;
        logic [6:0]      cursor_col;
        logic [4:0]      window_rows;
    } desc_t;

    // values handled here never exceed 256
    function automatic dec_t dec_split(input logic [8:0] v);
        dec_t        d;
        logic [8:0]  r;
        logic [14:0] p;
        logic [6:0]  t10;
        d = '0;
        if (v >= 9'd200)
        begin
            d.hun = 2'd2;
            r = v - 9'd200;
        end
        else if (v >= 9'd100)
        begin
            d.hun = 2'd1;
            r = v - 9'd100;
        end
        else
        begin
            d.hun = 2'd0;
            r = v;
        end
        // divide by ten through reciprocal multiply
        p = 15'(r[6:0]) * 15'd205;
        d.ten = p[14:11];
        t10 = 7'(d.ten) * 7'd10;
        d.one = 4'(r[6:0] - t10);
        if (v >= 9'd100)
            d.ndig = 2'd3;
        else if (v >= 9'd10)
            d.ndig = 2'd2;
        else
            d.ndig = 2'd1;
        return d;
    endfunction

    function automatic seg_t mk_seg(input logic [1:0] kind, input logic [7:0] code,
                                    input logic [8:0] n1, input logic [8:0] n2);
        seg_t s;
        s.kind = kind;
        s.code = code;
        s.num1 = dec_split(n1);
        s.num2 = dec_split(n2);
        return s;
    endfunction

    function automatic logic [2:0] str_len(input logic [7:0] id);
        logic [2:0] n;
        unique case (id) inside
            STR_WRAP_OFF, STR_WRAP_ON: n = 3'd5;
            STR_EOL:                   n = 3'd3;
            default:                   n = 3'd4;
        endcase
        return n;
    endfunction

    // bytes from index 2 on; the first two are always ESC and '['
    function automatic logic [7:0] str_byte(input logic [7:0] id, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (id)
            STR_INV:      b = (idx == 3'd2) ? 8'h37 : 8'h6d;
            STR_NORM:     b = (idx == 3'd2) ? 8'h30 : 8'h6d;
            STR_WRAP_OFF: b = (idx == 3'd2) ? 8'h3f : (idx == 3'd3) ? 8'h37 : 8'h6c;
            STR_WRAP_ON:  b = (idx == 3'd2) ? 8'h3f : (idx == 3'd3) ? 8'h37 : 8'h68;
            STR_CLEAR:    b = (idx == 3'd2) ? 8'h32 : 8'h4a;
            STR_EOL:      b = 8'h4b;
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ansi_terminal_command_formatter_top.sv =====
// top level of the terminal command formatter
// the first byte of a command passes through the descriptor queue and the output register
// throughput: one output byte per cycle while m_tready is held high; a command sends
// 1 to 22 bytes (a put character sends 1, or 5 when the video mode flips)
// commands that send nothing are accepted but put nothing in the queue
// reset: asynchronous active-low rst_n clears cursor, window, inverse flag, queue and output
`timescale 1ns / 1ps
`default_nettype none

module ansi_terminal_command_formatter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // value_a [7:0], value_b [15:8]
    input  wire logic [3:0]  s_tuser,   // command [3:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_byte [7:0], cursor_row [12:8],
                                        // cursor_col [19:13], window_rows [24:20], zero
    output logic             m_tlast    // last
);

    logic            push;
    atcf_pkg::desc_t push_desc;
    logic            q_full;
    logic            head_valid;
    atcf_pkg::desc_t head_desc;
    logic            pop;
    logic [7:0]      out_byte;
    logic [4:0]      cursor_row;
    logic [6:0]      cursor_col;
    logic [4:0]      window_rows;

    atcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .command   (s_tuser),
        .value_a   (s_tdata[7:0]),
        .value_b   (s_tdata[15:8]),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .push      (push),
        .push_desc (push_desc)
    );

    atcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    atcf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_desc   (head_desc),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (out_byte),
        .out_last    (m_tlast),
        .cursor_row  (cursor_row),
        .cursor_col  (cursor_col),
        .window_rows (window_rows)
    );

    assign m_tdata = {7'd0, window_rows, cursor_col, cursor_row, out_byte};

endmodule

`default_nettype wire

// ===== rtl/core/atcf_front.sv =====
// front end: accepts commands, tracks terminal state and builds output descriptors
`timescale 1ns / 1ps
`default_nettype none

module atcf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [3:0]    command,
    input  wire logic [7:0]    value_a,
    input  wire logic [7:0]    value_b,
    input  wire logic          q_full,
    output logic               in_ready,
    output logic               push,
    output atcf_pkg::desc_t    push_desc
);

    logic [4:0] row_reg, row_next;
    logic [6:0] col_reg, col_next;
    logic [7:0] wbot_reg, wbot_next;
    logic [4:0] wsize_reg, wsize_next;
    logic       inv_reg, inv_next;

    logic       emit;
    logic       accept;
    logic [8:0] wsz9;
    logic [4:0] wsz;
    logic [6:0] cur_x;
    logic [4:0] cur_y;
    logic [8:0] wb9;
    logic [8:0] lim;
    logic [8:0] nrows;
    logic       ctrl_char;
    logic [7:0] shown;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && emit;

    always_comb
    begin
        // window size, saturated at both ends
        wsz9 = {1'b0, value_b} - {1'b0, value_a} + 9'd1;
        if (value_b < value_a)
            wsz = 5'd0;
        else if (wsz9 > 9'd31)
            wsz = 5'd31;
        else
            wsz = wsz9[4:0];

        cur_x = (value_a > 8'(atcf_pkg::COL_MAX)) ? atcf_pkg::COL_MAX : value_a[6:0];
        cur_y = (value_b > 8'(atcf_pkg::ROW_MAX)) ? atcf_pkg::ROW_MAX : value_b[4:0];

        wb9 = {1'b0, wbot_reg} + 9'd1;
        lim = (wb9 >= {4'd0, row_reg}) ? (wb9 - {4'd0, row_reg}) : 9'd0;
        nrows = ({1'b0, value_a} > lim) ? lim : {1'b0, value_a};

        ctrl_char = (value_a < 8'd32) || (value_a >= 8'd127);
        shown = (value_a < 8'd32) ? (value_a + atcf_pkg::CH_AT) : atcf_pkg::CH_X;
    end

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        wbot_next  = wbot_reg;
        wsize_next = wsize_reg;
        inv_next   = inv_reg;
        emit       = 1'b0;
        push_desc  = '0;

        unique case (command) inside
            atcf_pkg::CMD_PUT:
            begin
                if (col_reg < atcf_pkg::PUT_COL_LIMIT)
                begin
                    emit = 1'b1;
                    col_next = col_reg + 7'd1;
                    if (ctrl_char)
                    begin
                        inv_next = 1'b1;
                        if (!inv_reg)
                        begin
                            push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_STR,
                                atcf_pkg::STR_INV, 9'd0, 9'd0);
                            push_desc.seg[1] = atcf_pkg::mk_seg(atcf_pkg::SEG_CHR, shown,
                                9'd0, 9'd0);
                            push_desc.last_seg = 2'd1;
                        end
                        else
                        begin
                            push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_CHR, shown,
                                9'd0, 9'd0);
                        end
                    end
                    else
                    begin
                        inv_next = 1'b0;
                        if (inv_reg)
                        begin
                            push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_STR,
                                atcf_pkg::STR_NORM, 9'd0, 9'd0);
                            push_desc.seg[1] = atcf_pkg::mk_seg(atcf_pkg::SEG_CHR, value_a,
                                9'd0, 9'd0);
                            push_desc.last_seg = 2'd1;
                        end
                        else
                        begin
                            push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_CHR, value_a,
                                9'd0, 9'd0);
                        end
                    end
                end
            end
            atcf_pkg::CMD_SETCUR:
            begin
                emit = 1'b1;
                push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_CSI2, atcf_pkg::CH_H,
                    {4'd0, cur_y} + 9'd1, {2'd0, cur_x} + 9'd1);
                row_next = cur_y;
                col_next = cur_x;
            end
            atcf_pkg::CMD_WINDOW:
            begin
                emit = 1'b1;
                push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_CSI2, atcf_pkg::CH_R,
                    {1'b0, value_a} + 9'd1, {1'b0, value_b} + 9'd1);
                row_next   = 5'd0;
                col_next   = 7'd0;
                wbot_next  = value_b;
                wsize_next = wsz;
            end
            atcf_pkg::CMD_DELROWS, atcf_pkg::CMD_INSROWS:
            begin
                emit = 1'b1;
                push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_CSI1,
                    (command == atcf_pkg::CMD_DELROWS) ? atcf_pkg::CH_M : atcf_pkg::CH_L,
                    nrows, 9'd0);
                col_next = 7'd0;
            end
            atcf_pkg::CMD_CLEAR:
            begin
                emit = 1'b1;
                push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_STR, atcf_pkg::STR_CLEAR,
                    9'd0, 9'd0);
                row_next = 5'd0;
                col_next = 7'd0;
            end
            atcf_pkg::CMD_EOL:
            begin
                emit = 1'b1;
                push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_STR, atcf_pkg::STR_EOL,
                    9'd0, 9'd0);
            end
            atcf_pkg::CMD_ATTR:
            begin
                // attribute codes above one send nothing
                if (value_a == 8'd0 || value_a == 8'd1)
                begin
                    emit = 1'b1;
                    push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_STR,
                        (value_a == 8'd0) ? atcf_pkg::STR_NORM : atcf_pkg::STR_INV,
                        9'd0, 9'd0);
                end
            end
            atcf_pkg::CMD_INIT:
            begin
                emit = 1'b1;
                push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_STR,
                    atcf_pkg::STR_WRAP_OFF, 9'd0, 9'd0);
                push_desc.seg[1] = atcf_pkg::mk_seg(atcf_pkg::SEG_STR,
                    atcf_pkg::STR_CLEAR, 9'd0, 9'd0);
                push_desc.seg[2] = atcf_pkg::mk_seg(atcf_pkg::SEG_CSI2, atcf_pkg::CH_R,
                    9'd1, 9'(atcf_pkg::SCREEN_ROWS - 1));
                push_desc.last_seg = 2'd2;
                row_next   = 5'd0;
                col_next   = 7'd0;
                wbot_next  = 8'(atcf_pkg::SCREEN_ROWS - 2);
                wsize_next = 5'(atcf_pkg::SCREEN_ROWS - 1);
            end
            atcf_pkg::CMD_RESTORE:
            begin
                emit = 1'b1;
                push_desc.seg[0] = atcf_pkg::mk_seg(atcf_pkg::SEG_CSI2, atcf_pkg::CH_R,
                    9'd1, 9'(atcf_pkg::SCREEN_ROWS));
                push_desc.seg[1] = atcf_pkg::mk_seg(atcf_pkg::SEG_CSI2, atcf_pkg::CH_H,
                    9'(atcf_pkg::SCREEN_ROWS), 9'd1);
                push_desc.seg[2] = atcf_pkg::mk_seg(atcf_pkg::SEG_STR,
                    atcf_pkg::STR_EOL, 9'd0, 9'd0);
                push_desc.seg[3] = atcf_pkg::mk_seg(atcf_pkg::SEG_STR,
                    atcf_pkg::STR_WRAP_ON, 9'd0, 9'd0);
                push_desc.last_seg = 2'd3;
                row_next   = atcf_pkg::ROW_MAX;
                col_next   = 7'd0;
                wbot_next  = 8'(atcf_pkg::SCREEN_ROWS - 1);
                wsize_next = 5'(atcf_pkg::SCREEN_ROWS);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        push_desc.cursor_row  = row_next;
        push_desc.cursor_col  = col_next;
        push_desc.window_rows = wsize_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= 5'd0;
            col_reg   <= 7'd0;
            wbot_reg  <= 8'd0;
            wsize_reg <= 5'd0;
            inv_reg   <= 1'b0;
        end
        else if (accept)
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            wbot_reg  <= wbot_next;
            wsize_reg <= wsize_next;
            inv_reg   <= inv_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/atcf_queue.sv =====
// short descriptor queue between the front end and the byte sequencer
`timescale 1ns / 1ps
`default_nettype none

module atcf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire atcf_pkg::desc_t push_desc,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output atcf_pkg::desc_t    head_desc
);

    localparam int PW = (atcf_pkg::QUEUE_DEPTH > 1) ? $clog2(atcf_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(atcf_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(atcf_pkg::QUEUE_DEPTH - 1);

    atcf_pkg::desc_t entry_reg [atcf_pkg::QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    assign full       = (count_reg == CW'(atcf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/atcf_back.sv =====
// back end: walks the head descriptor and sends one byte per cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none

module atcf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire atcf_pkg::desc_t head_desc,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               out_last,
    output logic [4:0]         cursor_row,
    output logic [6:0]         cursor_col,
    output logic [4:0]         window_rows
);

    localparam logic [3:0] PH_ESC  = 4'd0;
    localparam logic [3:0] PH_LB   = 4'd1;
    localparam logic [3:0] PH_STR  = 4'd2;
    localparam logic [3:0] PH_N1H  = 4'd3;
    localparam logic [3:0] PH_N1T  = 4'd4;
    localparam logic [3:0] PH_N1O  = 4'd5;
    localparam logic [3:0] PH_SEMI = 4'd6;
    localparam logic [3:0] PH_N2H  = 4'd7;
    localparam logic [3:0] PH_N2T  = 4'd8;
    localparam logic [3:0] PH_N2O  = 4'd9;
    localparam logic [3:0] PH_FIN  = 4'd10;

    logic [3:0] phase_reg, phase_next;
    logic [1:0] seg_idx_reg, seg_idx_next;
    logic [2:0] sidx_reg, sidx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic [4:0] row_reg, row_next;
    logic [6:0] col_reg, col_next;
    logic [4:0] ws_reg, ws_next;

    atcf_pkg::seg_t cur;
    logic           step;
    logic           end_seg;
    logic           is_last;
    logic [7:0]     cur_byte;
    logic [3:0]     adv;
    logic [3:0]     n1_first;
    logic [3:0]     n2_first;

    assign cur  = head_desc.seg[seg_idx_reg];
    // output register free or being drained
    assign step = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        n1_first = (cur.num1.ndig == 2'd3) ? PH_N1H :
                   (cur.num1.ndig == 2'd2) ? PH_N1T : PH_N1O;
        n2_first = (cur.num2.ndig == 2'd3) ? PH_N2H :
                   (cur.num2.ndig == 2'd2) ? PH_N2T : PH_N2O;
        cur_byte = 8'h00;
        end_seg  = 1'b0;
        adv      = phase_reg;
        sidx_next = sidx_reg;

        unique case (phase_reg)
            PH_ESC:
            begin
                if (cur.kind == atcf_pkg::SEG_CHR)
                begin
                    cur_byte = cur.code;
                    end_seg  = 1'b1;
                end
                else
                begin
                    cur_byte = atcf_pkg::CH_ESC;
                end
                adv = PH_LB;
            end
            PH_LB:
            begin
                cur_byte = atcf_pkg::CH_LB;
                if (cur.kind == atcf_pkg::SEG_STR)
                begin
                    adv = PH_STR;
                    sidx_next = 3'd2;
                end
                else
                begin
                    adv = n1_first;
                end
            end
            PH_STR:
            begin
                cur_byte = atcf_pkg::str_byte(cur.code, sidx_reg);
                end_seg  = (sidx_reg == atcf_pkg::str_len(cur.code) - 3'd1);
                sidx_next = sidx_reg + 3'd1;
            end
            PH_N1H:
            begin
                cur_byte = atcf_pkg::CH_ZERO + {6'd0, cur.num1.hun};
                adv = PH_N1T;
            end
            PH_N1T:
            begin
                cur_byte = atcf_pkg::CH_ZERO + {4'd0, cur.num1.ten};
                adv = PH_N1O;
            end
            PH_N1O:
            begin
                cur_byte = atcf_pkg::CH_ZERO + {4'd0, cur.num1.one};
                adv = (cur.kind == atcf_pkg::SEG_CSI2) ? PH_SEMI : PH_FIN;
            end
            PH_SEMI:
            begin
                cur_byte = atcf_pkg::CH_SEMI;
                adv = n2_first;
            end
            PH_N2H:
            begin
                cur_byte = atcf_pkg::CH_ZERO + {6'd0, cur.num2.hun};
                adv = PH_N2T;
            end
            PH_N2T:
            begin
                cur_byte = atcf_pkg::CH_ZERO + {4'd0, cur.num2.ten};
                adv = PH_N2O;
            end
            PH_N2O:
            begin
                cur_byte = atcf_pkg::CH_ZERO + {4'd0, cur.num2.one};
                adv = PH_FIN;
            end
            PH_FIN:
            begin
                cur_byte = cur.code;
                end_seg  = 1'b1;
            end
            default:
            begin
                end_seg = 1'b1;
            end
        endcase

        is_last = end_seg && (seg_idx_reg == head_desc.last_seg);
        pop     = step && is_last;

        phase_next   = phase_reg;
        seg_idx_next = seg_idx_reg;
        if (step)
        begin
            if (end_seg)
            begin
                phase_next   = PH_ESC;
                seg_idx_next = is_last ? 2'd0 : seg_idx_reg + 2'd1;
            end
            else
            begin
                phase_next = adv;
            end
        end
        if (!step)
            sidx_next = sidx_reg;

        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ws_next        = ws_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            byte_next      = cur_byte;
            last_next      = is_last;
            row_next       = head_desc.cursor_row;
            col_next       = head_desc.cursor_col;
            ws_next        = head_desc.window_rows;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ESC;
            seg_idx_reg   <= 2'd0;
            sidx_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            seg_idx_reg   <= seg_idx_next;
            sidx_reg      <= sidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        ws_reg   <= ws_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = byte_reg;
    assign out_last    = last_reg;
    assign cursor_row  = row_reg;
    assign cursor_col  = col_reg;
    assign window_rows = ws_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_ansi_terminal_command_formatter_top.sv =====
// self-checking testbench for the terminal command formatter
`timescale 1ns / 1ps

module tb_ansi_terminal_command_formatter_top;
    import atcf_pkg::*;

    localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam logic [7:0] ATTR_NORMAL   = 8'd0;
    localparam logic [7:0] ATTR_INVERSE  = 8'd1;
    localparam int         ITEMS_PER_PHASE = 50;
    localparam int         DRAIN_CYCLES    = 30;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic [4:0] row;
        logic [6:0] col;
        logic [4:0] wrows;
    } term_byte_t;

    typedef struct {
        logic [3:0] cmd;
        logic [7:0] a;
        logic [7:0] b;
        bit         typed;
        string      seq;
        int         row;
        int         col;
        int         wrows;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // value_a [7:0], value_b [15:8]
    logic [3:0]  s_tuser = '0;   // command [3:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // out_byte [7:0], cursor_row [12:8], cursor_col [19:13],
                                 // window_rows [24:20], zero
    logic        m_tlast;

    // terminal state as the formatter should track it
    logic [4:0] trk_row;
    logic [6:0] trk_col;
    logic [7:0] trk_win_bottom;
    logic [4:0] trk_win_size;
    bit         trk_inverse;

    logic [7:0] cmd_bytes[$];
    term_byte_t pending_bytes[$];
    plan_row_t  plan[$];

    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    ansi_terminal_command_formatter_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void emit_text(input string s);
        for (int i = 0; i < s.len(); i++)
            cmd_bytes.push_back(s[i]);
    endfunction

    // decimal without leading zeros
    function automatic void emit_number(input int v);
        if (v >= 100)
            cmd_bytes.push_back(8'(CH_ZERO + (v / 100) % 10));
        if (v >= 10)
            cmd_bytes.push_back(8'(CH_ZERO + (v / 10) % 10));
        cmd_bytes.push_back(8'(CH_ZERO + v % 10));
    endfunction

    function automatic void apply_window(input int top, input int bot);
        int size;
        emit_text("\033[");
        emit_number(top + 1);
        cmd_bytes.push_back(CH_SEMI);
        emit_number(bot + 1);
        cmd_bytes.push_back(CH_R);
        trk_row = '0;
        trk_col = '0;
        trk_win_bottom = 8'(bot);
        size = (bot >= top) ? bot - top + 1 : 0;
        trk_win_size = (size > 31) ? 5'd31 : 5'(size);
    endfunction

    function automatic void apply_cursor(input int x, input int y);
        if (x > SCREEN_COLS - 1)
            x = SCREEN_COLS - 1;
        if (y > SCREEN_ROWS - 1)
            y = SCREEN_ROWS - 1;
        emit_text("\033[");
        emit_number(y + 1);
        cmd_bytes.push_back(CH_SEMI);
        emit_number(x + 1);
        cmd_bytes.push_back(CH_H);
        trk_col = 7'(x);
        trk_row = 5'(y);
    endfunction

    function automatic void apply_rows(input int n, input logic [7:0] final_ch);
        int lim;
        int bot1;
        bot1 = int'(trk_win_bottom) + 1;
        // cursor below the window leaves no room at all
        lim = (bot1 >= int'(trk_row)) ? bot1 - int'(trk_row) : 0;
        if (n > lim)
            n = lim;
        emit_text("\033[");
        emit_number(n);
        cmd_bytes.push_back(final_ch);
        trk_col = '0;
    endfunction

    function automatic void apply_clear();
        emit_text("\033[2J");
        trk_row = '0;
        trk_col = '0;
    endfunction

    // works out the byte stream of one command and advances the tracked state
    function automatic int format_command(input logic [3:0] cmd, input logic [7:0] a,
                                          input logic [7:0] b);
        cmd_bytes.delete();
        case (cmd)
            CMD_PUT:
            begin
                if (trk_col < PUT_COL_LIMIT)
                begin
                    if (a < 8'd32 || a >= 8'd127)
                    begin
                        if (!trk_inverse)
                            emit_text("\033[7m");
                        trk_inverse = 1'b1;
                        cmd_bytes.push_back((a < 8'd32) ? a + CH_AT : CH_X);
                    end
                    else
                    begin
                        if (trk_inverse)
                            emit_text("\033[0m");
                        trk_inverse = 1'b0;
                        cmd_bytes.push_back(a);
                    end
                    trk_col = trk_col + 7'd1;
                end
            end
            CMD_SETCUR:  apply_cursor(int'(a), int'(b));
            CMD_WINDOW:  apply_window(int'(a), int'(b));
            CMD_DELROWS: apply_rows(int'(a), CH_M);
            CMD_INSROWS: apply_rows(int'(a), CH_L);
            CMD_CLEAR:   apply_clear();
            CMD_EOL:     emit_text("\033[K");
            CMD_ATTR:
            begin
                if (a == ATTR_NORMAL)
                    emit_text("\033[0m");
                else if (a == ATTR_INVERSE)
                    emit_text("\033[7m");
            end
            CMD_INIT:
            begin
                emit_text("\033[?7l");
                apply_clear();
                apply_window(0, SCREEN_ROWS - 2);
            end
            CMD_RESTORE:
            begin
                apply_window(0, SCREEN_ROWS - 1);
                apply_cursor(0, SCREEN_ROWS - 1);
                emit_text("\033[K");
                emit_text("\033[?7h");
            end
            default:
            begin
            end
        endcase
        return cmd_bytes.size();
    endfunction

    function automatic void add_row(input logic [3:0] cmd, input logic [7:0] a,
                                    input logic [7:0] b, input bit typed, input string seq,
                                    input int row, input int col, input int wrows);
        plan_row_t r;
        r.cmd = cmd;
        r.a = a;
        r.b = b;
        r.typed = typed;
        r.seq = seq;
        r.row = row;
        r.col = col;
        r.wrows = wrows;
        plan.push_back(r);
    endfunction

    task automatic send_command(input logic [3:0] cmd, input logic [7:0] a,
                                input logic [7:0] b, input bit typed, input string seq,
                                input int row, input int col, input int wrows,
                                output int produced);
        term_byte_t e;
        int n;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n = format_command(cmd, a, b);
        if (typed)
        begin
            for (int i = 0; i < seq.len(); i++)
            begin
                e.ch = seq[i];
                e.last = (i == seq.len() - 1);
                e.row = 5'(row);
                e.col = 7'(col);
                e.wrows = 5'(wrows);
                pending_bytes.push_back(e);
            end
            n = seq.len();
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                e.ch = cmd_bytes[i];
                e.last = (i == n - 1);
                e.row = trk_row;
                e.col = trk_col;
                e.wrows = trk_win_size;
                pending_bytes.push_back(e);
            end
        end
        produced = n;
    endtask

    task automatic pick_random(output logic [3:0] cmd, output logic [7:0] a,
                               output logic [7:0] b);
        int r;
        r = $urandom_range(0, 99);
        a = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        if (r < 40)
        begin
            cmd = CMD_PUT;
            case ($urandom_range(0, 9))
                0, 1:    a = 8'($urandom_range(0, 31));
                2:       a = 8'($urandom_range(127, 255));
                3:       a = 8'($urandom_range(0, 255));
                default: a = 8'($urandom_range(32, 126));
            endcase
        end
        else if (r < 52)
        begin
            cmd = CMD_SETCUR;
            if ($urandom_range(0, 1) == 0)
            begin
                a = 8'($urandom_range(0, 90));
                b = 8'($urandom_range(0, 30));
            end
        end
        else if (r < 60)
        begin
            cmd = CMD_WINDOW;
            if ($urandom_range(0, 2) != 0)
            begin
                a = 8'($urandom_range(0, 30));
                b = 8'($urandom_range(0, 30));
            end
        end
        else if (r < 66)
            cmd = CMD_DELROWS;
        else if (r < 72)
            cmd = CMD_INSROWS;
        else if (r < 76)
            cmd = CMD_CLEAR;
        else if (r < 80)
            cmd = CMD_EOL;
        else if (r < 88)
        begin
            cmd = CMD_ATTR;
            if ($urandom_range(0, 3) != 0)
                a = 8'($urandom_range(0, 4));
        end
        else if (r < 92)
            cmd = CMD_INIT;
        else if (r < 95)
            cmd = CMD_RESTORE;
        else
            cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    // output side: check every transaction, then pick the next ready level
    initial
    begin
        term_byte_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $error("unexpected output byte %h", m_tdata[7:0]);
                    fail_count++;
                end
                else
                begin
                    e = pending_bytes.pop_front();
                    if (m_tdata[7:0] !== e.ch)
                    begin
                        $error("out_byte expected %h actual %h", e.ch, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("last expected %b actual %b", e.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[12:8] !== e.row)
                    begin
                        $error("cursor_row expected %0d actual %0d", e.row, m_tdata[12:8]);
                        fail_count++;
                    end
                    if (m_tdata[19:13] !== e.col)
                    begin
                        $error("cursor_col expected %0d actual %0d", e.col, m_tdata[19:13]);
                        fail_count++;
                    end
                    if (m_tdata[24:20] !== e.wrows)
                    begin
                        $error("window_rows expected %0d actual %0d", e.wrows,
                               m_tdata[24:20]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        logic [3:0] cmd;
        logic [7:0] a;
        logic [7:0] b;
        int produced;
        int done;

        trk_row = '0;
        trk_col = '0;
        trk_win_bottom = '0;
        trk_win_size = '0;
        trk_inverse = 1'b0;

        add_row(CMD_CLEAR,     8'd0,   8'd0,   1, "\033[2J", 0, 0, 0);
        add_row(CMD_UNUSED_HI, 8'd255, 8'd255, 1, "", 0, 0, 0);
        add_row(CMD_ATTR,      8'd2,   8'd0,   1, "", 0, 0, 0);
        add_row(CMD_ATTR,      8'd255, 8'd0,   1, "", 0, 0, 0);
        add_row(CMD_PUT,       8'd0,   8'd0,   1, "\033[7m@", 0, 1, 0);
        add_row(CMD_PUT,       8'd127, 8'd0,   1, "x", 0, 2, 0);
        add_row(CMD_PUT,       8'd255, 8'd0,   1, "x", 0, 3, 0);
        add_row(CMD_PUT,       8'd31,  8'd0,   1, "_", 0, 4, 0);
        add_row(CMD_PUT,       8'd32,  8'd0,   1, "\033[0m ", 0, 5, 0);
        add_row(CMD_PUT,       8'd126, 8'd0,   1, "~", 0, 6, 0);
        add_row(CMD_SETCUR,    8'd255, 8'd255, 1, "\033[24;80H", 23, 79, 0);
        add_row(CMD_PUT,       8'd65,  8'd0,   1, "", 23, 79, 0);
        // window too large, then inverted
        add_row(CMD_WINDOW,    8'd0,   8'd255, 1, "\033[1;256r", 0, 0, 31);
        add_row(CMD_WINDOW,    8'd255, 8'd0,   1, "\033[256;1r", 0, 0, 0);
        // cursor below the window
        add_row(CMD_SETCUR,    8'd0,   8'd5,   1, "\033[6;1H", 5, 0, 0);
        add_row(CMD_DELROWS,   8'd255, 8'd0,   1, "\033[0M", 5, 0, 0);
        add_row(CMD_INSROWS,   8'd0,   8'd0,   1, "\033[0L", 5, 0, 0);
        add_row(CMD_INIT,      8'd0,   8'd0,   1, "\033[?7l\033[2J\033[1;23r", 0, 0, 23);
        add_row(CMD_DELROWS,   8'd255, 8'd0,   1, "\033[23M", 0, 0, 23);
        add_row(CMD_INSROWS,   8'd5,   8'd0,   0, "", 0, 0, 0);
        add_row(CMD_EOL,       8'd0,   8'd0,   1, "\033[K", 0, 0, 23);
        add_row(CMD_ATTR,      ATTR_NORMAL,  8'd0, 1, "\033[0m", 0, 0, 23);
        add_row(CMD_ATTR,      ATTR_INVERSE, 8'd0, 1, "\033[7m", 0, 0, 23);
        add_row(CMD_SETCUR,    8'd78,  8'd0,   0, "", 0, 0, 0);
        add_row(CMD_PUT,       8'd65,  8'd0,   0, "", 0, 0, 0);
        add_row(CMD_PUT,       8'd66,  8'd0,   0, "", 0, 0, 0);
        add_row(CMD_RESTORE,   8'd0,   8'd0,   1,
                "\033[1;24r\033[24;1H\033[K\033[?7h", 23, 0, 24);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_command(plan[i].cmd, plan[i].a, plan[i].b, plan[i].typed, plan[i].seq,
                         plan[i].row, plan[i].col, plan[i].wrows, produced);

        // no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 56;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 56;
                end
                default:
                begin
                    send_idle_pct = 16;
                    recv_stall_pct = 16;
                end
            endcase
            done = 0;
            while (done < ITEMS_PER_PHASE)
            begin
                pick_random(cmd, a, b);
                send_command(cmd, a, b, 0, "", 0, 0, 0, produced);
                if (produced > 0)
                    done++;
            end
            // hold the input until the output side has caught up
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_bytes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
